/* hw/rtl/mem31_pkg.sv */
package mem31_pkg;

  // Mersenne prime modulus and field width
  localparam int unsigned FW = 31;
  localparam logic [FW-1:0] MOD_P = '1;

  // Exponent bits that take part (1..64); the port carries at most FW bits
  localparam int unsigned EXP_BITS = 31;
  localparam logic [FW-1:0] EXP_MASK =
    (EXP_BITS >= FW) ? '1 : FW'((64'd1 << EXP_BITS) - 64'd1);

  // Multiplier digit: 16 bits of the squared operand per cycle, two digits per product
  localparam int unsigned DIG_W = 16;
  localparam int unsigned SH_W  = 2 * DIG_W;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned IN_DW  = 64;
  localparam int unsigned OUT_DW = 32;

  // One Horner step of a digit-serial mod-P multiply:
  // returns (part * 2^16 + a * d) mod P, with part < 2^31.
  // Times 2^16 mod (2^31-1) is a 31-bit rotate.
  function automatic logic [FW-1:0] mul_step(input logic [FW-1:0] part,
                                             input logic [FW-1:0] a,
                                             input logic [DIG_W-1:0] d);
    logic [FW+DIG_W-1:0] prod;
    logic [FW-1:0]       rot;
    logic [FW+1:0]       sum;
    logic [FW:0]         fold;
    logic [FW:0]         diff;
    prod = {{DIG_W{1'b0}}, a} * {{FW{1'b0}}, d};
    rot  = {part[FW-DIG_W-1:0], part[FW-1:FW-DIG_W]};
    sum  = {2'b00, rot} + {2'b00, prod[FW-1:0]} + {{(FW+2-DIG_W){1'b0}}, prod[FW+DIG_W-1:FW]};
    fold = {1'b0, sum[FW-1:0]} + {{(FW-1){1'b0}}, sum[FW+1:FW]};
    diff = fold - {1'b0, MOD_P};
    return (fold >= {1'b0, MOD_P}) ? diff[FW-1:0] : fold[FW-1:0];
  endfunction

endpackage

/* hw/rtl/mod_exp_mersenne31_top.sv */
// Modular exponentiation modulo 2^31-1, right-to-left square-and-multiply.
//
// Input channel in_*: one item = base and exponent, accepted when
// in_tvalid and in_tready are high at a rising edge. Output channel out_*:
// one result item per input item, base^exponent mod (2^31-1).
//
// Per exponent bit the squared operand is fed 16 bits per cycle from a
// digit shift register into two 31x16 multiply/fold lanes, one forming the
// square, the other the accumulator product. The loop stops after the
// highest set exponent bit; a zero exponent gives 1. in_tready stays low
// until the result is handed to the output register, so the block does not
// take a new item before it is through with the last one.
//
// Reset (rst_n low, synchronous) drops any item in progress and any
// pending result. The result sits in an output register; while the
// receiver stalls, the block still takes and works on the next item and
// waits at its end until the register is free.
module mod_exp_mersenne31_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mem31_pkg::IN_DW-1:0]    in_tdata,   // [30:0] base_value, [61:31] exponent
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mem31_pkg::OUT_DW-1:0]   out_tdata   // [30:0] power_mod
);
  import mem31_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic              phase_r, phase_nxt;
  logic [FW-1:0]     acc_r, acc_nxt;
  logic [FW-1:0]     sq_r, sq_nxt;
  logic [FW-1:0]     exp_r, exp_nxt;
  logic [SH_W-1:0]   dig_r, dig_nxt;
  logic [FW-1:0]     pacc_r, pacc_nxt;
  logic [FW-1:0]     psq_r, psq_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FW-1:0]     out_data_r, out_data_nxt;

  logic              in_acc;
  logic              out_free;
  logic [FW-1:0]     base_in;
  logic [FW-1:0]     base_red;
  logic [DIG_W-1:0]  dig;
  logic [FW-1:0]     part_acc;
  logic [FW-1:0]     part_sq;
  logic [FW-1:0]     step_acc;
  logic [FW-1:0]     step_sq;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // base reduction: only the value P itself needs it
  assign base_in  = in_tdata[FW-1:0];
  assign base_red = (base_in == MOD_P) ? '0 : base_in;

  // two multiply lanes share the current digit of the squared operand
  assign dig      = dig_r[SH_W-1:SH_W-DIG_W];
  assign part_acc = phase_r ? pacc_r : '0;
  assign part_sq  = phase_r ? psq_r  : '0;
  assign step_acc = mul_step(part_acc, acc_r, dig);
  assign step_sq  = mul_step(part_sq, sq_r, dig);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    exp_nxt       = exp_r;
    dig_nxt       = dig_r;
    pacc_nxt      = pacc_r;
    psq_nxt       = psq_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RUN;
          phase_nxt = 1'b0;
          acc_nxt   = FW'(1);
          sq_nxt    = base_red;
          dig_nxt   = {{(SH_W-FW){1'b0}}, base_red};
          exp_nxt   = in_tdata[2*FW-1:FW] & EXP_MASK;
        end
      end
      S_RUN: begin
        if (!phase_r) begin
          if (exp_r == '0) begin
            // no set bits left: hand the result over once the register is free
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = acc_r;
              state_nxt     = S_IDLE;
            end
          end else begin
            pacc_nxt  = step_acc;
            psq_nxt   = step_sq;
            dig_nxt   = {dig_r[SH_W-DIG_W-1:0], {DIG_W{1'b0}}};
            phase_nxt = 1'b1;
          end
        end else begin
          // last digit: products complete
          if (exp_r[0]) begin
            acc_nxt = step_acc;
          end
          sq_nxt    = step_sq;
          dig_nxt   = {{(SH_W-FW){1'b0}}, step_sq};
          exp_nxt   = {1'b0, exp_r[FW-1:1]};
          phase_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        phase_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    exp_r      <= exp_nxt;
    dig_r      <= dig_nxt;
    pacc_r     <= pacc_nxt;
    psq_r      <= psq_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-FW){1'b0}}, out_data_r};

  // a result is always a reduced residue
  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[FW-1:0] != MOD_P))
    else $error("result not reduced mod P");

  // accepted item starts a fresh power with the accumulator at one
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_RUN) && !phase_r && (acc_r == FW'(1)))
    else $error("item load failed");

  // second digit only inside a run
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (state_r == S_RUN))
    else $error("digit phase outside run");

  // operands stay reduced during the run
  a_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (acc_r != MOD_P) && (sq_r != MOD_P))
    else $error("operand left unreduced");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_data_r))
    else $error("pending result lost");

endmodule
